// ===== sv/mouse_packet_cursor_tracker_defines.svh =====
// Assertion macros shared by the cursor tracker modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MPCT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed in %m");

// Consequent that must hold in the cycle after the antecedent.
`define MPCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

// ===== sv/mpct_pkg.sv =====
package mpct_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned DeltaW = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CoordW-1:0] XLimitReset = 12'd1024;
  localparam logic [CoordW-1:0] YLimitReset = 12'd768;

  // Position of the next byte within its three-byte packet.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_X_LIMIT = 2'd0,
    REG_Y_LIMIT = 2'd1
  } cfg_reg_e;

  // One complete packet handed from the assembler to the cursor stage.
  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
  } pkt_t;

endpackage

// ===== sv/mpct_if.sv =====
// Byte stream from the mouse port.
interface mpct_byte_if import mpct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Decoded cursor requests.
interface mpct_res_if import mpct_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CoordW-1:0]        cursor_x;
  logic [CoordW-1:0]        cursor_y;
  logic signed [DeltaW-1:0] delta_x;
  logic signed [DeltaW-1:0] delta_y;
  logic                     left_button;
  logic                     right_button;
  logic                     middle_button;

  modport source (output valid, output cursor_x, output cursor_y, output delta_x,
                  output delta_y, output left_button, output right_button,
                  output middle_button, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input delta_x,
                  input delta_y, input left_button, input right_button,
                  input middle_button, output ready);
endinterface

// Configuration register writes.
interface mpct_cfg_if import mpct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CoordW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/mpct_assembler.sv =====
`include "mouse_packet_cursor_tracker_defines.svh"

module mpct_assembler import mpct_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mpct_byte_if.sink    in_if,
  output logic         pkt_valid_o,
  input  logic         pkt_ready_i,
  output pkt_t         pkt_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] b0_q, b1_q;
  pkt_t             pkt_q;
  logic             pkt_valid_q, pkt_valid_d;
  logic             accept;
  logic             third;

  // A new byte is taken whenever the packet register is free or draining.
  assign in_if.ready = !pkt_valid_q || pkt_ready_i;
  assign accept      = in_if.valid && in_if.ready;
  assign third       = (phase_q == PH_THIRD);

  // Phase counter; the unused code falls back to the first byte.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_SECOND: phase_d = PH_THIRD;
        PH_THIRD:  phase_d = PH_FIRST;
        default:   phase_d = PH_SECOND;
      endcase
    end
  end

  // Packet register valid flag.
  always_comb begin
    pkt_valid_d = pkt_valid_q;
    if (pkt_ready_i) begin
      pkt_valid_d = 1'b0;
    end
    if (accept && third) begin
      pkt_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      pkt_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pkt_valid_q <= pkt_valid_d;
    end
  end

  // Stored bytes and the completed packet carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unique case (phase_q)
        PH_SECOND: b1_q <= in_if.data_byte;
        PH_THIRD:  pkt_q <= '{b0: b0_q, b1: b1_q, b2: in_if.data_byte};
        default:   b0_q <= in_if.data_byte;
      endcase
    end
  end

  assign pkt_valid_o = pkt_valid_q;
  assign pkt_o       = pkt_q;

  // A third byte always produces a packet in the following cycle.
  `MPCT_ASSERT_NEXT(a_third_loads_pkt, accept && third, pkt_valid_q)
  // A packet waiting downstream blocks the input.
  `MPCT_ASSERT(a_stall_blocks_input, (pkt_valid_q && !pkt_ready_i) |-> !in_if.ready)

endmodule

// ===== sv/mpct_cursor.sv =====
`include "mouse_packet_cursor_tracker_defines.svh"

module mpct_cursor import mpct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pkt_valid_i,
  output logic              pkt_ready_o,
  input  pkt_t              pkt_i,
  input  logic [CoordW-1:0] x_limit_i,
  input  logic [CoordW-1:0] y_limit_i,
  mpct_res_if.source        out_if
);

  localparam int unsigned SumW = CoordW + 2;

  logic signed [DeltaW-1:0] dx, dy;
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic [CoordW-1:0]        pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                     out_valid_q, out_valid_d;
  logic                     load;
  logic signed [DeltaW-1:0] dx_q, dy_q;
  logic [2:0]               btn_q;

  // Output register takes a packet when empty or being drained.
  assign pkt_ready_o = !out_valid_q || out_if.ready;
  assign load        = pkt_valid_i && pkt_ready_o;

  // Sign bits 4 and 5 of the first byte extend the movements to 9 bits.
  assign dx = {pkt_i.b0[4], pkt_i.b1};
  assign dy = {pkt_i.b0[5], pkt_i.b2};

  assign sum_x = $signed({2'b00, pos_x_q}) + SumW'(dx);
  assign sum_y = $signed({2'b00, pos_y_q}) + SumW'(dy);

  // Clamp each coordinate to zero through its limit.
  always_comb begin
    if (sum_x < 0) begin
      pos_x_d = '0;
    end else if (sum_x > $signed({2'b00, x_limit_i})) begin
      pos_x_d = x_limit_i;
    end else begin
      pos_x_d = sum_x[CoordW-1:0];
    end
    if (sum_y < 0) begin
      pos_y_d = '0;
    end else if (sum_y > $signed({2'b00, y_limit_i})) begin
      pos_y_d = y_limit_i;
    end else begin
      pos_y_d = sum_y[CoordW-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  // Kept position doubles as the cursor field of the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dx_q  <= dx;
      dy_q  <= dy;
      btn_q <= pkt_i.b0[2:0];
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.cursor_x      = pos_x_q;
  assign out_if.cursor_y      = pos_y_q;
  assign out_if.delta_x       = dx_q;
  assign out_if.delta_y       = dy_q;
  assign out_if.left_button   = btn_q[0];
  assign out_if.right_button  = btn_q[1];
  assign out_if.middle_button = btn_q[2];

  // A freshly clamped position never exceeds the limit it was clamped to.
  `MPCT_ASSERT_NEXT(a_x_clamped, load, pos_x_q <= $past(x_limit_i))
  `MPCT_ASSERT_NEXT(a_y_clamped, load, pos_y_q <= $past(y_limit_i))
  // Position only moves when a packet enters the output register.
  `MPCT_ASSERT_NEXT(a_pos_hold, !load, $stable(pos_x_q) && $stable(pos_y_q))

endmodule

// ===== sv/mouse_packet_cursor_tracker.sv =====
// Accepts one mouse byte per cycle while the input is not stalled by a waiting packet; a
// packet's result passes through the packet register, loaded when its third byte is accepted,
// and then the output register, which loads once it is empty or being drained.
// Sustained throughput without back-pressure is one byte per cycle, so one packet per three bytes.
// Reset clears the byte phase and the cursor to zero and sets the limits to 1024 and
// 768; the two stored packet bytes are not reset.
module mouse_packet_cursor_tracker import mpct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpct_byte_if.sink  in_if,
  mpct_res_if.source out_if,
  mpct_cfg_if.sink   cfg_if
);

  logic              pkt_valid;
  logic              pkt_ready;
  pkt_t              pkt;
  logic [CoordW-1:0] x_limit_q, y_limit_q;

  // Limit registers; writes to unknown indexes are dropped.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= XLimitReset;
      y_limit_q <= YLimitReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_X_LIMIT: x_limit_q <= cfg_if.data;
        REG_Y_LIMIT: y_limit_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  mpct_assembler u_assembler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .pkt_valid_o (pkt_valid),
    .pkt_ready_i (pkt_ready),
    .pkt_o       (pkt)
  );

  mpct_cursor u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (pkt_valid),
    .pkt_ready_o (pkt_ready),
    .pkt_i       (pkt),
    .x_limit_i   (x_limit_q),
    .y_limit_i   (y_limit_q),
    .out_if      (out_if)
  );

endmodule

// ===== verif/mouse_packet_cursor_tracker_test.sv =====
`timescale 1ns / 100ps

module mouse_packet_cursor_tracker_test;
  import mpct_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles = 300;

  // One decoded cursor request as the block should report it.
  typedef struct packed {
    logic [CoordW-1:0]        x;
    logic [CoordW-1:0]        y;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic                     left_btn;
    logic                     right_btn;
    logic                     middle_btn;
  } cursor_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic hold_off = 1'b0;

  logic [ByteW-1:0] byte_backlog[$];
  cursor_report_t   due_reports[$];

  // Shadow copy of the tracker state and its limits.
  phase_e            trk_phase;
  logic [ByteW-1:0]  trk_b0;
  logic [ByteW-1:0]  trk_b1;
  logic [CoordW-1:0] trk_x;
  logic [CoordW-1:0] trk_y;
  logic [CoordW-1:0] lim_x;
  logic [CoordW-1:0] lim_y;

  int unsigned feed_gap = 0;
  int unsigned feed_calm = 0;
  int unsigned drain_gap = 0;
  int unsigned drain_calm = 0;
  int unsigned reports_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned fill_pos = 0;

  mpct_byte_if byte_ch();
  mpct_res_if  res_ch();
  mpct_cfg_if  cfg_ch();

  mouse_packet_cursor_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (byte_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  always #2 clk_i = ~clk_i;

  // Idle length for either side: mostly short, a few long, with calm stretches.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      calm = $urandom_range(60, 10);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Add a signed movement to a coordinate and clamp it to 0..lim.
  function automatic logic [CoordW-1:0] clamp_move(logic [CoordW-1:0] pos,
                                                   logic signed [DeltaW-1:0] d,
                                                   logic [CoordW-1:0] lim);
    int sum;
    sum = int'(pos) + int'(d);
    if (sum < 0) return '0;
    if (sum > int'(lim)) return lim;
    return sum[CoordW-1:0];
  endfunction

  // Advance the packet assembler by one byte; the third byte yields a report.
  task automatic track_byte(logic [ByteW-1:0] b);
    cursor_report_t rep;
    case (trk_phase)
      PH_SECOND: begin
        trk_b1 = b;
        trk_phase = PH_THIRD;
      end
      PH_THIRD: begin
        trk_phase = PH_FIRST;
        rep.dx = {trk_b0[4], trk_b1};
        rep.dy = {trk_b0[5], b};
        trk_x = clamp_move(trk_x, rep.dx, lim_x);
        trk_y = clamp_move(trk_y, rep.dy, lim_y);
        rep.x = trk_x;
        rep.y = trk_y;
        rep.left_btn = trk_b0[0];
        rep.right_btn = trk_b0[1];
        rep.middle_btn = trk_b0[2];
        due_reports.push_back(rep);
      end
      default: begin
        trk_b0 = b;
        trk_phase = PH_SECOND;
      end
    endcase
  endtask

  // Movement bytes lean toward the extremes now and then.
  function automatic logic [ByteW-1:0] pick_move();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return 8'(ByteW'($urandom_range(4)));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CoordW-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == REG_X_LIMIT) lim_x = val;
    else lim_y = val;
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every byte has been taken and every report has come back.
  task automatic settle();
    do @(negedge clk_i);
    while (byte_backlog.size() > 0 || byte_ch.valid || due_reports.size() > 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) begin
      if (fill_pos == 0) byte_backlog.push_back(8'($urandom_range(255)));
      else byte_backlog.push_back(pick_move());
      fill_pos = (fill_pos + 1) % 3;
    end
  endtask

  // Byte driver: offers the backlog with random gaps and tracks accepted bytes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) track_byte(byte_ch.data_byte);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          byte_ch.valid <= 1'b0;
        end else if (byte_backlog.size() > 0) begin
          byte_ch.valid <= 1'b1;
          byte_ch.data_byte <= byte_backlog.pop_front();
          feed_gap = pick_gap(feed_calm);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: compares each accepted request with the oldest one due.
  always @(posedge clk_i) begin : drain
    cursor_report_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        reports_seen++;
        if (due_reports.size() == 0) begin
          $error("cursor request arrived with none due");
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          if (res_ch.cursor_x !== want.x) begin
            $error("cursor_x: expected %0d, got %0d", want.x, res_ch.cursor_x);
            mismatches++;
          end
          if (res_ch.cursor_y !== want.y) begin
            $error("cursor_y: expected %0d, got %0d", want.y, res_ch.cursor_y);
            mismatches++;
          end
          if (res_ch.delta_x !== want.dx) begin
            $error("delta_x: expected %0d, got %0d", want.dx, res_ch.delta_x);
            mismatches++;
          end
          if (res_ch.delta_y !== want.dy) begin
            $error("delta_y: expected %0d, got %0d", want.dy, res_ch.delta_y);
            mismatches++;
          end
          if (res_ch.left_button !== want.left_btn) begin
            $error("left_button: expected %0b, got %0b", want.left_btn, res_ch.left_button);
            mismatches++;
          end
          if (res_ch.right_button !== want.right_btn) begin
            $error("right_button: expected %0b, got %0b", want.right_btn,
                   res_ch.right_button);
            mismatches++;
          end
          if (res_ch.middle_button !== want.middle_btn) begin
            $error("middle_button: expected %0b, got %0b", want.middle_btn,
                   res_ch.middle_button);
            mismatches++;
          end
        end
      end
      if (hold_off) begin
        res_ch.ready <= 1'b0;
      end else if (drain_gap > 0) begin
        drain_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ((res_ch.valid && res_ch.ready) || $urandom_range(3) == 0)
          drain_gap = pick_gap(drain_calm);
      end
    end
  end

  // One long receiver hold-off in the middle of the random traffic, so the
  // block backs up and stalls its byte input.
  initial begin
    wait (reports_seen >= 60);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus sequence: reset, directed packets, then random phases at
  // several limit settings.
  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_X_LIMIT;
    cfg_ch.data = '0;
    trk_phase = PH_FIRST;
    trk_b0 = '0;
    trk_b1 = '0;
    trk_x = '0;
    trk_y = '0;
    lim_x = XLimitReset;
    lim_y = YLimitReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed packets at the reset limits. Largest negative moves clamp at zero,
    // overflow bits set with all buttons, then repeated largest positive moves
    // until the y coordinate pins at its limit, then one step back and negative
    // moves on both axes with every header bit set.
    byte_backlog = '{8'h38, 8'h00, 8'h00,
                     8'hC7, 8'hFF, 8'hFF,
                     8'h08, 8'hFF, 8'hFF,
                     8'h00, 8'hFF, 8'hFF,
                     8'h40, 8'hFF, 8'hFF,
                     8'h31, 8'hFF, 8'hFF,
                     8'hFF, 8'h80, 8'h7F,
                     8'h02, 8'h01, 8'h80};
    settle();

    // Random phases; the random lengths can leave a packet half-done across a limit change.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_X_LIMIT, 12'd0);
          write_reg(REG_Y_LIMIT, 12'd4095);
        end
        1: begin
          write_reg(REG_X_LIMIT, 12'd4095);
          write_reg(REG_Y_LIMIT, 12'd0);
        end
        3: begin
          write_reg(REG_X_LIMIT, 12'd1);
          write_reg(REG_Y_LIMIT, 12'd2);
        end
        5: begin
          write_reg(REG_X_LIMIT, XLimitReset);
          write_reg(REG_Y_LIMIT, YLimitReset);
        end
        default: begin
          write_reg(REG_X_LIMIT, 12'($urandom_range(4095)));
          write_reg(REG_Y_LIMIT, 12'($urandom_range(4095)));
        end
      endcase
      @(negedge clk_i);
      queue_random($urandom_range(110, 85));
      settle();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
